// ----- hdl/mxbfq_pkg.sv -----
// Shared types and constants for the MX block fake-quantizer.
// Used by the controller, the datapath and the top level; no dependencies.
package mxbfq_pkg;

	// element formats
	localparam logic [1:0] FMT_FP16 = 2'd0;
	localparam logic [1:0] FMT_BF16 = 2'd1;
	localparam logic [1:0] FMT_FP32 = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_FORMAT    = 2'd0;
	localparam logic [1:0] REG_EXP_MAX   = 2'd1;
	localparam logic [1:0] REG_MAX_NORM  = 2'd2;
	localparam logic [1:0] REG_MANT_BITS = 2'd3;

	// register reset values
	localparam logic [1:0]        RST_FORMAT    = FMT_FP32;
	localparam logic signed [7:0] RST_EXP_MAX   = 8'sd2;
	localparam logic [31:0]       RST_MAX_NORM  = 32'h40C0_0000;
	localparam logic [4:0]        RST_MANT_BITS = 5'd1;

	// quiet NaN produced by infinity times zero
	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;

	typedef struct packed {
		logic load;
		logic calc_se;
		logic issue;
		logic issue_last;
	} dp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} dp_sts_t;

endpackage

// ----- hdl/mxbfq_ctrl.sv -----
// Controller for the MX block fake-quantizer: load, exponent, emit and drain phases.
// Depends on mxbfq_pkg for the command and status structs.
module mxbfq_ctrl import mxbfq_pkg::*; #(
	parameter int BLOCK_SIZE = 64,
	localparam int IDX_W = $clog2(BLOCK_SIZE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  dp_sts_t          sts,
	output logic             busy,
	output dp_cmd_t          cmd,
	output logic [IDX_W-1:0] wr_idx,
	output logic [IDX_W-1:0] rd_idx
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_SEXP  = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_SIZE - 1);

	logic [1:0]       state_q;
	logic [IDX_W-1:0] fill_q;
	logic [IDX_W-1:0] rd_q;

	always_comb begin
		busy           = (state_q != ST_LOAD);
		cmd.load       = start && (state_q == ST_LOAD);
		cmd.calc_se    = (state_q == ST_SEXP);
		cmd.issue      = (state_q == ST_EMIT);
		cmd.issue_last = (state_q == ST_EMIT) && (rd_q == LAST_IDX);
		wr_idx         = fill_q;
		rd_idx         = rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			rd_q    <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (cmd.load) begin
						if (fill_q == LAST_IDX) begin
							fill_q  <= '0;
							state_q <= ST_SEXP;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_SEXP: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.issue_last) begin
						rd_q    <= '0;
						state_q <= ST_DRAIN;
					end else begin
						rd_q <= rd_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// hold until the last request has left the pipeline
					if (!sts.pipe_busy) begin
						state_q <= ST_LOAD;
					end
				end
			endcase
		end
	end

	a_sexp_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEXP) |=> (state_q == ST_EMIT))
		else $error("exponent phase not followed by emission");

	a_last_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_last |=> (state_q == ST_DRAIN))
		else $error("emission continued past the last request");

	a_full_to_sexp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (fill_q == LAST_IDX)) |=> cmd.calc_se)
		else $error("full block did not start exponent phase");

endmodule

// ----- hdl/mxbfq_dp.sv -----
// Datapath for the MX block fake-quantizer: config registers, element store,
// block maximum, shared exponent and the emission pipeline. Depends on mxbfq_pkg.
module mxbfq_dp import mxbfq_pkg::*; #(
	parameter int BLOCK_SIZE = 64,
	localparam int IDX_W = $clog2(BLOCK_SIZE)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic [IDX_W-1:0]    rd_idx,
	input  logic [31:0]         elem_bits,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output dp_sts_t             sts,
	output logic                result_valid,
	output logic [31:0]         quant_bits,
	output logic signed [7:0]   shared_exponent,
	output logic                last_of_block
);

	localparam int NST = 9;

	typedef struct packed {
		logic               sign;
		logic               zero;
		logic               inf;
		logic               nan;
		logic [23:0]        sig;
		logic signed [9:0]  ex;
	} norm_t;

	function automatic logic [24:0] rnd_shr(input logic [23:0] sig, input logic [4:0] sh);
		logic [24:0] s25;
		logic [24:0] mask;
		logic [24:0] rem;
		logic [24:0] half;
		logic [24:0] q;
		s25  = {1'b0, sig};
		mask = (25'd1 << sh) - 25'd1;
		rem  = s25 & mask;
		half = 25'd1 << (sh - 5'd1);
		q    = s25 >> sh;
		if (rem > half || (rem == half && q[0])) begin
			q = q + 25'd1;
		end
		return q;
	endfunction

	function automatic logic [31:0] h2s(input logic [15:0] h);
		logic [4:0]  ex;
		logic [9:0]  man;
		logic [3:0]  p;
		logic [9:0]  man_n;
		logic [31:0] w;
		ex  = h[14:10];
		man = h[9:0];
		p   = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) p = 4'(i);
		end
		man_n = man << (4'd10 - p);
		if (ex == 5'd0) begin
			if (man == 10'd0) w = {h[15], 31'd0};
			else              w = {h[15], 8'd103 + {4'd0, p}, man_n, 13'd0};
		end else if (ex == 5'h1F) begin
			w = {h[15], 8'hFF, man, 13'd0};
		end else begin
			w = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
		end
		return w;
	endfunction

	function automatic logic [31:0] widen(input logic [31:0] raw, input logic [1:0] fmt);
		logic [31:0] w;
		priority case (fmt)
			FMT_FP32: w = raw;
			FMT_BF16: w = {raw[15:0], 16'd0};
			default:  w = h2s(raw[15:0]);
		endcase
		return w;
	endfunction

	function automatic logic signed [7:0] se_of(input logic [30:0] m,
			input logic signed [7:0] emax);
		logic [7:0]        ex;
		logic [22:0]       frac;
		logic signed [9:0] lg;
		logic signed [9:0] s;
		ex   = m[30:23];
		frac = m[22:0];
		if (ex == 8'd0)       lg = -10'sd126;
		else if (ex == 8'hFF) lg = 10'sd129;
		else lg = $signed({2'b00, ex}) - 10'sd127 + ((frac > 23'h60_0000) ? 10'sd1 : 10'sd0);
		s = lg - $signed({{2{emax[7]}}, emax});
		if (s > 10'sd127)  s = 10'sd127;
		if (s < -10'sd127) s = -10'sd127;
		if (m == 31'd0 || (ex == 8'hFF && frac != 23'd0)) s = 10'sd0;
		return s[7:0];
	endfunction

	function automatic norm_t fp_norm(input logic [31:0] u);
		norm_t      n;
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (u[i]) p = 5'(i);
		end
		n.sign = u[31];
		n.zero = (u[30:0] == 31'd0);
		n.inf  = (u[30:23] == 8'hFF) && (u[22:0] == 23'd0);
		n.nan  = (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
		if (u[30:23] != 8'd0) begin
			n.sig = {1'b1, u[22:0]};
			n.ex  = $signed({2'b00, u[30:23]});
		end else begin
			// subnormal: bring the leading one up to the hidden position
			n.sig = {1'b0, u[22:0]} << (5'd23 - p);
			n.ex  = $signed({5'd0, p}) - 10'sd22;
		end
		return n;
	endfunction

	// multiply by 2^k, or by a zero of the same sign when zs is set, rounding to nearest even
	function automatic logic [31:0] fp_scale(input norm_t n, input logic signed [8:0] k,
			input logic zs);
		logic signed [10:0] nexp;
		logic [4:0]         sh;
		logic [24:0]        q;
		logic [31:0]        r;
		nexp = $signed({n.ex[9], n.ex}) + $signed({{2{k[8]}}, k});
		sh   = (nexp < -11'sd23) ? 5'd25 : 5'(11'sd1 - nexp);
		q    = rnd_shr(n.sig, sh);
		if (n.nan)                  r = {n.sign, 8'hFF, 1'b1, n.sig[21:0]};
		else if (zs)                r = n.inf ? QNAN_DEFAULT : {n.sign, 31'd0};
		else if (n.inf)             r = {n.sign, 8'hFF, 23'd0};
		else if (n.zero)            r = {n.sign, 31'd0};
		else if (nexp >= 11'sd255)  r = {n.sign, 8'hFF, 23'd0};
		else if (nexp >= 11'sd1)    r = {n.sign, nexp[7:0], n.sig[22:0]};
		else                        r = {n.sign, 6'd0, q};
		return r;
	endfunction

	// round to mb fraction bits relative to max(own power of two, 1)
	function automatic logic [31:0] fp_quant(input logic [31:0] u, input logic [4:0] mb);
		logic [7:0]        f;
		logic signed [9:0] shr;
		logic [4:0]        sh;
		logic [24:0]       s25;
		logic [24:0]       mask;
		logic [24:0]       rem;
		logic [24:0]       keep;
		logic [24:0]       half;
		logic [24:0]       rr;
		logic              inc;
		logic [31:0]       r;
		f    = u[30:23];
		shr  = ((f >= 8'd127) ? 10'sd23 : (10'sd150 - $signed({2'b00, f})))
			- $signed({5'd0, mb});
		sh   = shr[4:0];
		s25  = {2'b01, u[22:0]};
		mask = (25'd1 << sh) - 25'd1;
		rem  = s25 & mask;
		keep = s25 & ~mask;
		half = 25'd1 << (sh - 5'd1);
		inc  = (rem > half) || (rem == half && s25[sh]);
		rr   = keep + (inc ? (25'd1 << sh) : 25'd0);
		if (f == 8'd0)            r = 32'd0;
		else if (shr <= 10'sd0)   r = u;
		else if (shr >= 10'sd25)  r = 32'd0;
		else if (rr == 25'd0)     r = 32'd0;
		else if (rr[24])          r = {u[31], f + 8'd1, 23'd0};
		else                      r = {u[31], f, rr[22:0]};
		return r;
	endfunction

	function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ka;
		logic [31:0] kb;
		logic        lt;
		ka = a[31] ? ~a : (a | 32'h8000_0000);
		kb = b[31] ? ~b : (b | 32'h8000_0000);
		lt = (ka < kb);
		if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) || (b[30:23] == 8'hFF && b[22:0] != 23'd0))
			lt = 1'b0;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			lt = 1'b0;
		return lt;
	endfunction

	function automatic logic [15:0] to_half(input logic [31:0] u);
		logic signed [9:0] e;
		logic [14:0]       q;
		logic [24:0]       qs;
		logic [15:0]       h;
		e  = $signed({2'b00, u[30:23]}) - 10'sd112;
		q  = {e[4:0], u[22:13]};
		qs = rnd_shr({1'b1, u[22:0]}, 5'(10'sd14 - e));
		if (u[12:0] > 13'h1000 || (u[12:0] == 13'h1000 && q[0])) q = q + 15'd1;
		if (u[30:23] == 8'hFF)
			h = {u[31], 5'h1F, (u[22:0] != 23'd0) ? {1'b1, u[21:13]} : 10'd0};
		else if (e >= 10'sd31)  h = {u[31], 15'h7C00};
		else if (e < -10'sd10)  h = {u[31], 15'd0};
		else if (e <= 10'sd0)   h = {u[31], qs[14:0]};
		else                    h = {u[31], q};
		return h;
	endfunction

	function automatic logic [15:0] to_bf(input logic [31:0] u);
		logic [31:0] sum;
		logic [15:0] b;
		sum = u + 32'h0000_7FFF + {31'd0, u[16]};
		if (u[30:0] > 31'h7F80_0000) b = u[31:16] | 16'h0040;
		else                          b = sum[31:16];
		return b;
	endfunction

	function automatic logic [31:0] narrow(input logic [31:0] r, input logic [1:0] fmt);
		logic [31:0] o;
		priority case (fmt)
			FMT_FP32: o = r;
			FMT_BF16: o = {16'd0, to_bf(r)};
			default:  o = {16'd0, to_half(r)};
		endcase
		return o;
	endfunction

	logic [1:0]        fmt_q;
	logic signed [7:0] emax_q;
	logic [31:0]       mn_q;
	logic [4:0]        mb_q;
	logic [30:0]       max_q;
	logic signed [7:0] se_q;
	logic [31:0]       elem_mem_q [BLOCK_SIZE];
	logic [NST-1:0]    vld_q;
	logic [NST-1:0]    lst_q;

	logic [31:0] w;
	logic [31:0] neg_mn;
	logic signed [8:0] k_inv;
	logic signed [8:0] k_fwd;
	logic zs;

	logic [31:0] x_s1;
	norm_t       n_s2;
	logic [31:0] xs_s3;
	logic [31:0] a_s4;
	logic [31:0] c_s5;
	logic [31:0] c_s6;
	norm_t       n_s7;
	logic [31:0] r_s8;
	logic [31:0] quant_q;

	always_comb begin
		w      = widen(elem_bits, fmt_q);
		neg_mn = {~mn_q[31], mn_q[30:0]};
		k_fwd  = $signed({se_q[7], se_q});
		k_inv  = -k_fwd;
		zs     = (se_q == -8'sd127);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= RST_FORMAT;
			emax_q <= RST_EXP_MAX;
			mn_q   <= RST_MAX_NORM;
			mb_q   <= RST_MANT_BITS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FORMAT:    fmt_q  <= cfg_data[1:0];
				REG_EXP_MAX:   emax_q <= $signed(cfg_data[7:0]);
				REG_MAX_NORM:  mn_q   <= cfg_data;
				REG_MANT_BITS: mb_q   <= cfg_data[4:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			se_q  <= '0;
			vld_q <= '0;
			lst_q <= '0;
		end else begin
			if (cmd.calc_se) begin
				se_q  <= se_of(max_q, emax_q);
				max_q <= '0;
			end else if (cmd.load && (w[30:0] > max_q)) begin
				max_q <= w[30:0];
			end
			vld_q <= {vld_q[NST-2:0], cmd.issue};
			lst_q <= {lst_q[NST-2:0], cmd.issue_last};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			elem_mem_q[wr_idx] <= w;
		end
		if (cmd.issue) begin
			x_s1 <= elem_mem_q[rd_idx];
		end
	end

	// emission pipeline: scale down, quantize, clamp, scale up, narrow
	always_ff @(posedge clk) begin
		n_s2    <= fp_norm(x_s1);
		xs_s3   <= fp_scale(n_s2, k_inv, zs);
		a_s4    <= fp_quant(xs_s3, mb_q);
		c_s5    <= fp_lt(mn_q, a_s4) ? mn_q : a_s4;
		c_s6    <= fp_lt(c_s5, neg_mn) ? neg_mn : c_s5;
		n_s7    <= fp_norm(c_s6);
		r_s8    <= fp_scale(n_s7, k_fwd, zs);
		quant_q <= narrow(r_s8, fmt_q);
	end

	assign sts.pipe_busy   = |vld_q;
	assign result_valid    = vld_q[NST-1];
	assign last_of_block   = lst_q[NST-1];
	assign quant_bits      = quant_q;
	assign shared_exponent = se_q;

	a_last_has_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_of_block |-> result_valid)
		else $error("last marker without a result");

	a_se_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && $past(result_valid)) |-> $stable(se_q))
		else $error("shared exponent changed within a block");

	a_se_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc_se |-> !(|vld_q))
		else $error("shared exponent updated while results in flight");

endmodule

// ----- hdl/mx_block_fake_quantizer.sv -----
// Top level of the MX block fake-quantizer (MXFP4-style shared-exponent quantization).
// Instantiates mxbfq_ctrl and mxbfq_dp; depends on mxbfq_pkg.
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------------------------
//  element   start & !busy             elem_bits
//  result    result_valid (1 cycle)    quant_bits, shared_exponent, last_of_block
//  config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Elements load one per cycle while busy is low; the last element of a block raises busy.
// A block of BLOCK_SIZE elements is loaded, its shared exponent is computed, then BLOCK_SIZE
// results leave one per cycle, read through the single read port of the element store and
// the emission pipeline.
// busy stays high until the last result has left; the receiver cannot stall results.
// Reset restores the default registers and an empty block; the store itself is not cleared.
module mx_block_fake_quantizer import mxbfq_pkg::*; #(
	parameter int BLOCK_SIZE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [31:0]       elem_bits,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output logic              result_valid,
	output logic [31:0]       quant_bits,
	output logic signed [7:0] shared_exponent,
	output logic              last_of_block
);

	localparam int IDX_W = $clog2(BLOCK_SIZE);

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] rd_idx;

	assign cfg_ready = 1'b1;

	mxbfq_ctrl #(
		.BLOCK_SIZE(BLOCK_SIZE)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd),
		.wr_idx (wr_idx),
		.rd_idx (rd_idx)
	);

	mxbfq_dp #(
		.BLOCK_SIZE(BLOCK_SIZE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.wr_idx          (wr_idx),
		.rd_idx          (rd_idx),
		.elem_bits       (elem_bits),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sts             (sts),
		.result_valid    (result_valid),
		.quant_bits      (quant_bits),
		.shared_exponent (shared_exponent),
		.last_of_block   (last_of_block)
	);

endmodule

// ----- bench/tb_mx_block_fake_quantizer.sv -----
// Self-checking bench for mx_block_fake_quantizer: directed and random blocks of elements.
// Holds its own bit-exact model of the fake-quantizer; depends on mxbfq_pkg and the RTL.
module tb_mx_block_fake_quantizer;
	import mxbfq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLK = 64;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [31:0]       q;
		logic signed [7:0] se;
		logic              last;
	} quant_res_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [31:0]       elem_bits;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [31:0]       cfg_data;
	logic              result_valid;
	logic [31:0]       quant_bits;
	logic signed [7:0] shared_exponent;
	logic              last_of_block;

	mx_block_fake_quantizer #(.BLOCK_SIZE(BLK)) dut (.*);

	// mirror of the block's registers and collecting state
	logic [1:0]  fmt_r;
	int          emax_r;
	logic [31:0] max_norm_r;
	logic [4:0]  mant_r;
	logic [31:0] widened[BLK];
	int          fill;
	logic [31:0] peak_mag;

	quant_res_t pending_q[$];
	int idle_pct;
	int fail_cnt, n_items, n_blocks, n_checked, stall_cnt;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ---------------- fp32 arithmetic helpers ----------------
	function automatic logic [63:0] rne_shift(logic [63:0] m, int sh);
		logic [63:0] q, rem, half;
		if (sh <= 0) return m;
		if (sh >= 64) return 64'd0;
		q = m >> sh;
		rem = m & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0])) q++;
		return q;
	endfunction

	function automatic logic [31:0] f32_of_real(real r);
		logic [63:0] d, m, q;
		int e;
		d = $realtobits(r);
		if (d[62:52] == 11'h7FF) return {d[63], (d[51:0] != 0) ? 31'h7FC0_0000 : 31'h7F80_0000};
		if (d[62:52] == 11'd0) return {d[63], 31'd0};
		e = int'(d[62:52]) - 1023;
		m = {11'd0, 1'b1, d[51:0]};
		if (e >= -126) begin
			q = rne_shift(m, 29);
			if (q[24]) begin
				q = q >> 1;
				e++;
			end
			if (e > 127) return {d[63], 8'hFF, 23'd0};
			return {d[63], 8'(e + 127), q[22:0]};
		end
		q = rne_shift(m, 29 + (-126 - e));
		return {d[63], q[30:0]};
	endfunction

	function automatic real real_of_f32(logic [31:0] u);
		real r;
		if (u[30:23] == 8'hFF) return $bitstoreal({u[31], 11'h7FF, u[22:0], 29'd0});
		if (u[30:23] != 8'd0)
			return $bitstoreal({u[31], 11'(int'(u[30:23]) + 896), u[22:0], 29'd0});
		r = real'(u[22:0]) * (2.0 ** (-149));
		return u[31] ? -r : r;
	endfunction

	function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
		return f32_of_real(real_of_f32(a) * real_of_f32(b));
	endfunction

	// round half-to-even to an integer; zero always comes back as +0
	function automatic logic [31:0] round_int(logic [31:0] u);
		logic [63:0] q;
		if (u[30:23] >= 8'd150) return u;
		if (u[30:23] < 8'd126) return 32'd0;
		q = rne_shift({40'd0, 1'b1, u[22:0]}, 150 - int'(u[30:23]));
		if (q == 0) return 32'd0;
		return f32_of_real(u[31] ? -real'(q) : real'(q));
	endfunction

	function automatic logic [31:0] half_to_single(logic [15:0] h);
		logic [31:0] man;
		int e;
		man = {22'd0, h[9:0]};
		if (h[14:10] == 5'd0) begin
			if (man == 0) return {h[15], 31'd0};
			e = 113;
			while (!man[10]) begin
				man = man << 1;
				e--;
			end
			return {h[15], 8'(e), man[9:0], 13'd0};
		end
		if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
		return {h[15], 8'(int'(h[14:10]) + 112), h[9:0], 13'd0};
	endfunction

	function automatic logic [31:0] single_to_half(logic [31:0] u);
		logic [15:0] s;
		logic [31:0] q, rem;
		int e;
		s = {u[31], 15'd0};
		if (u[30:23] == 8'hFF)
			return {16'd0, s | 16'h7C00 | ((u[22:0] != 0) ? (16'h200 | 16'(u[22:13])) : 16'h0)};
		e = int'(u[30:23]) - 127 + 15;
		if (e >= 31) return {16'd0, s | 16'h7C00};
		if (e <= 0) begin
			if (e < -10) return {16'd0, s};
			return {16'd0, s | 16'(rne_shift({40'd0, 1'b1, u[22:0]}, 14 - e))};
		end
		q = (32'(e) << 10) | 32'(u[22:13]);
		rem = {19'd0, u[12:0]};
		if (rem > 32'h1000 || (rem == 32'h1000 && q[0])) q++;
		return {16'd0, s | q[15:0]};
	endfunction

	function automatic logic [31:0] single_to_brain(logic [31:0] u);
		logic [31:0] t;
		if (u[30:0] > 31'h7F80_0000) return {16'd0, u[31:16] | 16'h40};
		t = u + 32'h7FFF + {31'd0, u[16]};
		return {16'd0, t[31:16]};
	endfunction

	function automatic int block_exponent(logic [31:0] m);
		int lg, s;
		if (m == 0 || (m[30:23] == 8'hFF && m[22:0] != 0)) return 0;
		if (m[30:23] == 8'd0) lg = -126;
		else if (m[30:23] == 8'hFF) lg = 129;
		else lg = int'(m[30:23]) - 127 + ((m[22:0] > 23'h60_0000) ? 1 : 0);
		s = lg - emax_r;
		if (s > 127) s = 127;
		if (s < -127) s = -127;
		return s;
	endfunction

	function automatic logic [31:0] fake_quant(logic [31:0] x, logic [31:0] scale,
			logic [31:0] scale_inv);
		logic [31:0] xs, priv, step, inv_step, a, t;
		xs = fmul(x, scale_inv);
		priv = {1'b0, xs[30:23], 23'd0};
		step = 32'(127 + int'(mant_r)) << 23;
		inv_step = f32_of_real(1.0 / real_of_f32(step));
		if (!(real_of_f32(priv) >= 1.0)) priv = 32'h3F80_0000;
		t = f32_of_real(real_of_f32(xs) / real_of_f32(priv));
		a = round_int(fmul(t, step));
		a = fmul(fmul(a, inv_step), priv);
		if (real_of_f32(a) > real_of_f32(max_norm_r)) a = max_norm_r;
		if (real_of_f32(a) < -real_of_f32(max_norm_r)) a = max_norm_r ^ 32'h8000_0000;
		return fmul(a, scale);
	endfunction

	// widen one accepted element; a full block yields its results
	function automatic void absorb_elem(logic [31:0] raw);
		logic [31:0] w, scale, sinv, r;
		int se;
		quant_res_t res;
		if (fmt_r == FMT_FP32) w = raw;
		else if (fmt_r == FMT_BF16) w = {raw[15:0], 16'd0};
		else w = half_to_single(raw[15:0]);
		widened[fill] = w;
		if ({1'b0, w[30:0]} > peak_mag) peak_mag = {1'b0, w[30:0]};
		fill++;
		if (fill < BLK) return;
		se = block_exponent(peak_mag);
		scale = (se < -126) ? 32'd0 : (32'(se + 127) << 23);
		sinv = (scale != 0) ? f32_of_real(1.0 / real_of_f32(scale)) : 32'd0;
		for (int i = 0; i < BLK; i++) begin
			r = fake_quant(widened[i], scale, sinv);
			if (fmt_r == FMT_BF16) r = single_to_brain(r);
			else if (fmt_r != FMT_FP32) r = single_to_half(r);
			res.q = r;
			res.se = 8'(se);
			res.last = (i == BLK - 1);
			pending_q.push_back(res);
		end
		fill = 0;
		peak_mag = 32'd0;
		n_blocks++;
	endfunction

	// ---------------- result checking and watchdog ----------------
	always @(posedge clk) begin
		quant_res_t want;
		if (arst_n && result_valid) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result quant_bits=%h", quant_bits);
				fail_cnt++;
			end else begin
				want = pending_q.pop_front();
				n_checked++;
				if (quant_bits !== want.q) begin
					$error("quant_bits: expected %h, got %h", want.q, quant_bits);
					fail_cnt++;
				end
				if (shared_exponent !== want.se) begin
					$error("shared_exponent: expected %0d, got %0d", want.se, shared_exponent);
					fail_cnt++;
				end
				if (last_of_block !== want.last) begin
					$error("last_of_block: expected %b, got %b", want.last, last_of_block);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) stall_cnt = 0;
		else stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("stalled for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------- request drivers ----------------
	task automatic send_elem(input logic [31:0] v);
		logic free;
		@(negedge clk);
		start <= 1'b1;
		elem_bits <= v;
		forever begin
			free = !busy;
			@(posedge clk);
			if (free) break;
			@(negedge clk);
		end
		absorb_elem(v);
		n_items++;
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// hold off until every result is in and the pipeline has emptied
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (15) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		logic rdy;
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			rdy = cfg_ready;
			@(posedge clk);
			if (rdy) break;
			@(negedge clk);
		end
		case (idx)
			REG_FORMAT:    fmt_r = data[1:0];
			REG_EXP_MAX:   emax_r = int'($signed(data[7:0]));
			REG_MAX_NORM:  max_norm_r = data;
			REG_MANT_BITS: mant_r = data[4:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [1:0] f, input int em, input logic [31:0] mn,
			input int mb);
		write_reg(REG_FORMAT, {30'd0, f});
		write_reg(REG_EXP_MAX, {$urandom_range(0, 255) << 8} | 32'(em & 8'hFF));
		write_reg(REG_MAX_NORM, mn);
		write_reg(REG_MANT_BITS, 32'(mb));
	endtask

	// finite random element for the current format; upper bits random for 16-bit formats
	function automatic logic [31:0] rand_elem();
		logic [31:0] v;
		int pick;
		v = $urandom;
		pick = $urandom_range(0, 9);
		if (fmt_r == FMT_FP32) begin
			if (pick == 0) v[30:23] = $urandom_range(0, 3) == 0 ? 8'd0 : $urandom_range(1, 20);
			else if (pick == 1) v[30:23] = $urandom_range(200, 254);
			else v[30:23] = $urandom_range(118, 134);
		end else if (fmt_r == FMT_BF16) begin
			if (pick == 0) v[14:7] = $urandom_range(0, 3) == 0 ? 8'd0 : $urandom_range(1, 20);
			else if (pick == 1) v[14:7] = $urandom_range(200, 254);
			else v[14:7] = $urandom_range(118, 134);
		end else begin
			if (pick == 0) v[14:10] = 5'd0;
			else v[14:10] = $urandom_range(1, 30);
		end
		return v;
	endfunction

	// send the given elements, then pad until the block is complete
	task automatic send_block(input logic [31:0] vals[$]);
		foreach (vals[i]) send_elem(vals[i]);
		while (fill != 0) send_elem(rand_elem());
	endtask

	// ---------------- tests ----------------
	task automatic test_default_extremes();
		logic [31:0] zeros[$];
		send_block('{32'h0, 32'h8000_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h1, 32'h8000_0001,
			32'h007F_FFFF, 32'h3FC0_0000, 32'h3F20_0000, 32'h4020_0000, 32'hBF40_0000});
		// leading elements with magnitude right at and just above 1.75; random padding fills the rest
		send_block('{32'h3FE0_0000, 32'hBF00_0000, 32'h3F40_0000});
		send_block('{32'hBFE0_0001, 32'h3E80_0000});
		// all-zero block gives a shared exponent of zero
		for (int i = 0; i < BLK; i++) zeros.push_back((i % 2) ? 32'h8000_0000 : 32'h0);
		send_block(zeros);
	endtask

	task automatic test_register_extremes();
		write_all(FMT_FP32, -127, 32'h0, 0);
		send_block('{32'h7F7F_FFFF, 32'h0000_0001});
		write_all(FMT_FP32, 127, 32'hC0C0_0000, 22);
		send_block('{32'h3F80_0000});
		write_all(2'd3, 0, 32'h7F7F_FFFF, 31);
		send_block('{32'h0000_7BFF, 32'hFFFF_8001, 32'h0000_0400});
		write_all(FMT_BF16, -2, 32'h4700_0000, 23);
		send_block('{32'h1234_7F7F, 32'h0000_8001});
		write_all(FMT_FP16, 3, 32'h3F80_0000, 0);
		send_block('{32'h0000_3C00, 32'h0000_BE00});
	endtask

	task automatic test_format_switch();
		write_all(FMT_FP16, 2, 32'h40C0_0000, 1);
		for (int i = 0; i < BLK / 2; i++) send_elem(rand_elem());
		write_reg(REG_FORMAT, {30'd0, FMT_BF16});
		send_block('{});
	endtask

	task automatic test_random_blocks(input int nblk);
		int pcts[3] = '{0, 58, 34};
		logic [31:0] mn;
		int em, mb;
		for (int b = 0; b < nblk; b++) begin
			em = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 254)) - 127
				: int'($urandom_range(0, 8)) - 4;
			mn = ($urandom_range(0, 4) == 0) ? $urandom
				: {1'b0, 8'($urandom_range(126, 131)), 23'($urandom)};
			mb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
			write_all($urandom_range(0, 3), em, mn, mb);
			idle_pct = pcts[b % 3];
			send_block('{});
		end
		idle_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		elem_bits = 32'd0;
		cfg_valid = 1'b0;
		cfg_index = REG_FORMAT;
		cfg_data = 32'd0;
		fmt_r = RST_FORMAT;
		emax_r = int'(RST_EXP_MAX);
		max_norm_r = RST_MAX_NORM;
		mant_r = RST_MANT_BITS;
		fill = 0;
		peak_mag = 32'd0;
		idle_pct = 0;
		fail_cnt = 0;
		n_items = 0;
		n_blocks = 0;
		n_checked = 0;
		stall_cnt = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_default_extremes();
		test_register_extremes();
		test_format_switch();
		test_random_blocks(8);

		drain();
		repeat (20) @(negedge clk);
		$display("sent %0d elements in %0d blocks, checked %0d results", n_items, n_blocks,
			n_checked);
		$display("covered all formats, register extremes and mid-block format change");
		if (fail_cnt == 0 && pending_q.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- mx_block_fake_quantizer.f -----
hdl/mxbfq_pkg.sv
hdl/mxbfq_ctrl.sv
hdl/mxbfq_dp.sv
hdl/mx_block_fake_quantizer.sv
bench/tb_mx_block_fake_quantizer.sv
